[rtl/core/pst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;

   localparam int unsigned DEF_MAX_PARTICLES = 256;
   localparam int unsigned DEF_SINE_ENTRIES  = 1024;

   localparam int unsigned KIND_W  = 2;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned POS_W   = 19;
   localparam int unsigned HEAD_W  = 16;
   localparam int unsigned NCNT_W  = 8;
   localparam int unsigned STEP_W  = 32;
   localparam int unsigned COORD_W = 18;
   localparam int unsigned SIZE_W  = 19;
   localparam int unsigned TRIG_W  = 17;
   localparam int unsigned MODV_W  = 21;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] REG_PCOUNT = 3'd0;
   localparam logic [2:0] REG_FWIDTH = 3'd1;
   localparam logic [2:0] REG_FHEIGHT = 3'd2;
   localparam logic [2:0] REG_RADIUS = 3'd3;
   localparam logic [2:0] REG_SPEED  = 3'd4;
   localparam logic [2:0] REG_BTURN  = 3'd5;
   localparam logic [2:0] REG_NTURN  = 3'd6;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_WMODX, S_WMODXW, S_WMODY, S_WMODYW,
      S_PRD, S_PDAT,
      S_OWN_RD, S_OWN_DAT, S_TRIG_C, S_TRIG_W,
      S_J_RD, S_J_DAT, S_J_MUL, S_J_EVAL,
      S_DISP, S_MODX, S_MODXW, S_MODY, S_MODYW,
      S_WB, S_RESP
   } state_type;

   // whole pixels clamped to 1..1024, then scaled to position units
   function automatic logic [SIZE_W-1:0] torus_size(input logic [10:0] pix);
      logic [10:0] c;
      begin
         c = pix;
         if (pix == 11'd0) c = 11'd1;
         if (pix > 11'd1024) c = 11'd1024;
         torus_size = {c, 8'd0};
      end
   endfunction

endpackage
`default_nettype wire

[rtl/core/pst_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface pst_req_if;
   import pst_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [INDEX_W-1:0]  index;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [HEAD_W-1:0]   heading;
   modport source(output valid, kind, index, pos_x, pos_y, heading, input ready);
   modport sink(input valid, kind, index, pos_x, pos_y, heading, output ready);
endinterface
`default_nettype wire

[rtl/core/pst_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface pst_rsp_if;
   import pst_pkg::*;
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  index_res;
   logic [POS_W-1:0]    pos_x_res;
   logic [POS_W-1:0]    pos_y_res;
   logic [HEAD_W-1:0]   heading_res;
   logic [NCNT_W-1:0]   neighbours;
   logic [STEP_W-1:0]   step_count;
   modport source(output valid, index_res, pos_x_res, pos_y_res, heading_res, neighbours,
                  step_count, input ready);
   modport sink(input valid, index_res, pos_x_res, pos_y_res, heading_res, neighbours,
                step_count, output ready);
endinterface
`default_nettype wire

[rtl/core/particle_swarm_torus_step_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake        payload
// req_chan  in   valid / ready    kind, index, pos_x, pos_y, heading
// rsp_chan  out  valid / ready    index_res, pos_x_res, pos_y_res, heading_res,
//                                 neighbours, step_count
// csr       in   apb psel/penable pwrite, paddr, pwdata, prdata, pready
//
// one request at a time; a write takes longer than a read (two serial modulo runs)
// step: each particle in turn goes through the single pair unit
//   that fetches one neighbour per pass from the particle memory read port
// after reset a clearing pass over all MAX_PARTICLES entries zeroes the neighbour counts
// the result register lets a new request in while the last result waits
module particle_swarm_torus_step_core #(
   parameter int unsigned MAX_PARTICLES = pst_pkg::DEF_MAX_PARTICLES,
   parameter int unsigned SINE_ENTRIES  = pst_pkg::DEF_SINE_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   pst_req_if.sink                           req_chan,
   pst_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pst_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pst_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pst_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import pst_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_PARTICLES);
   localparam int unsigned CW    = AW + 1;
   localparam int unsigned PAW   = $clog2(2 * MAX_PARTICLES);
   localparam int unsigned PMW   = 2 * COORD_W + HEAD_W;

   // configuration
   logic [8:0]  pc_ff;
   logic [10:0] fw_ff, fh_ff;
   logic [15:0] rad_ff, base_ff, nt_ff;
   logic [11:0] spd_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= 9'd256;
         fw_ff   <= 11'd512;
         fh_ff   <= 11'd512;
         rad_ff  <= 16'd1280;
         spd_ff  <= 12'd170;
         base_ff <= 16'd32768;
         nt_ff   <= 16'd3094;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PCOUNT:  pc_ff   <= pwdata[8:0];
            REG_FWIDTH:  fw_ff   <= pwdata[10:0];
            REG_FHEIGHT: fh_ff   <= pwdata[10:0];
            REG_RADIUS:  rad_ff  <= pwdata[15:0];
            REG_SPEED:   spd_ff  <= pwdata[11:0];
            REG_BTURN:   base_ff <= pwdata[15:0];
            REG_NTURN:   nt_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PCOUNT:  prdata = 32'(pc_ff);
         REG_FWIDTH:  prdata = 32'(fw_ff);
         REG_FHEIGHT: prdata = 32'(fh_ff);
         REG_RADIUS:  prdata = 32'(rad_ff);
         REG_SPEED:   prdata = 32'(spd_ff);
         REG_BTURN:   prdata = 32'(base_ff);
         REG_NTURN:   prdata = 32'(nt_ff);
         default:     prdata = '0;
      endcase
   end

   // derived sizes
   logic [SIZE_W-1:0] wsz, hsz;
   logic [CW-1:0]     n_use;
   logic [31:0]       rad2_ff;

   assign wsz   = torus_size(fw_ff);
   assign hsz   = torus_size(fh_ff);
   assign n_use = (32'(pc_ff) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(pc_ff);

   always_ff @(posedge clock) begin
      rad2_ff <= rad_ff * rad_ff;
   end

   // state
   state_type state_ff, state_in;
   logic      bank_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic [CW-1:0] l_ff, r_ff;

   logic [KIND_W-1:0]  kind_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [POS_W-1:0]   px_ff, py_ff;
   logic [HEAD_W-1:0]  head_ff;

   logic [COORD_W-1:0] xi_ff, yi_ff, newx_ff, newy_ff;
   logic [HEAD_W-1:0]  hi_ff, ang_ff, newh_ff;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff;
   logic signed [19:0] dx_ff, dy_ff;
   logic signed [39:0] pxx_ff, pyy_ff;
   logic signed [36:0] psx_ff, pcy_ff;
   logic signed [15:0] dispx_ff, dispy_ff;

   logic [INDEX_W-1:0] res_idx_ff;
   logic [POS_W-1:0]   res_x_ff, res_y_ff;
   logic [HEAD_W-1:0]  res_h_ff;
   logic [NCNT_W-1:0]  res_n_ff;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [POS_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [HEAD_W-1:0]  rsp_h_ff;
   logic [NCNT_W-1:0]  rsp_n_ff;
   logic [STEP_W-1:0]  rsp_s_ff;

   // memories and units
   logic           pm_wr_en, pm_rd_en;
   logic [PAW-1:0] pm_wr_addr, pm_rd_addr;
   logic [PMW-1:0] pm_wr_data, pm_rd_data;
   logic           nm_wr_en, nm_rd_en;
   logic [AW-1:0]  nm_wr_addr, nm_rd_addr;
   logic [NCNT_W-1:0] nm_wr_data, nm_rd_data;

   logic                     mod_start, mod_done;
   logic signed [MODV_W-1:0] mod_value;
   logic [SIZE_W-1:0]        mod_modulus;
   logic [COORD_W-1:0]       mod_result;

   logic                     sn_valid, sn_tag, sn_out_valid, sn_out_tag;
   logic [HEAD_W-1:0]        sn_angle;
   logic signed [TRIG_W-1:0] sn_value;

   pst_ram #(.WIDTH(PMW), .DEPTH(2 * MAX_PARTICLES)) u_pmem (
      .clock(clock), .wr_en(pm_wr_en), .wr_addr(pm_wr_addr), .wr_data(pm_wr_data),
      .rd_en(pm_rd_en), .rd_addr(pm_rd_addr), .rd_data(pm_rd_data)
   );

   pst_ram #(.WIDTH(NCNT_W), .DEPTH(MAX_PARTICLES)) u_nmem (
      .clock(clock), .wr_en(nm_wr_en), .wr_addr(nm_wr_addr), .wr_data(nm_wr_data),
      .rd_en(nm_rd_en), .rd_addr(nm_rd_addr), .rd_data(nm_rd_data)
   );

   pst_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .value(mod_value),
      .modulus(mod_modulus), .done(mod_done), .result(mod_result)
   );

   pst_sine u_sine (
      .clock(clock), .reset(reset), .in_valid(sn_valid), .in_tag(sn_tag),
      .angle(sn_angle), .out_valid(sn_out_valid), .out_tag(sn_out_tag), .value(sn_value)
   );

   // combinational helpers
   logic            req_acc, rsp_free, idx_ok, copy, last_i;
   logic [PAW-1:0]  ob_base, nb_base;
   logic [COORD_W-1:0] ox, oy;
   logic [HEAD_W-1:0]  oh;
   logic [31:0]     qk;
   logic [HEAD_W-1:0] qang;
   logic signed [19:0] dxr, dyr, dxw, dyw, halfw, halfh, fullw, fullh;
   logic signed [40:0] dist2;
   logic signed [37:0] side;
   logic signed [29:0] vx, vy;
   logic [CW-1:0]   tot;
   logic [HEAD_W-1:0] nmul, turn;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign idx_ok   = 32'(idx_ff) < MAX_PARTICLES;
   assign copy     = i_ff >= n_use;
   assign last_i   = i_ff == CW'(MAX_PARTICLES - 1);
   assign ob_base  = bank_ff ? PAW'(MAX_PARTICLES) : '0;
   assign nb_base  = bank_ff ? '0 : PAW'(MAX_PARTICLES);
   assign {ox, oy, oh} = pm_rd_data;

   always_comb begin
      qk    = (32'(oh) * SINE_ENTRIES) >> 16;
      qang  = 16'((qk << 16) / SINE_ENTRIES);
      fullw = 20'(wsz);
      fullh = 20'(hsz);
      halfw = 20'(wsz >> 1);
      halfh = 20'(hsz >> 1);
      dxr   = $signed({2'b00, ox}) - $signed({2'b00, xi_ff});
      dyr   = $signed({2'b00, oy}) - $signed({2'b00, yi_ff});
      dxw   = (dxr > halfw) ? dxr - fullw : ((dxr < -halfw) ? dxr + fullw : dxr);
      dyw   = (dyr > halfh) ? dyr - fullh : ((dyr < -halfh) ? dyr + fullh : dyr);
      dist2 = 41'(pxx_ff) + 41'(pyy_ff);
      side  = 38'(pcy_ff) - 38'(psx_ff);
      vx    = cos_ff * $signed({1'b0, spd_ff});
      vy    = sin_ff * $signed({1'b0, spd_ff});
      tot   = l_ff + r_ff;
      nmul  = 16'(nt_ff * tot);
      turn  = (l_ff > r_ff) ? base_ff + nmul : base_ff - nmul;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (last_i) state_in = S_IDLE;
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_chan.kind)
                  KIND_WRITE: state_in = S_WMODX;
                  KIND_READ:  state_in = S_PRD;
                  KIND_STEP:  state_in = S_OWN_RD;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_WMODX:   state_in = S_WMODXW;
         S_WMODXW:  if (mod_done) state_in = S_WMODY;
         S_WMODY:   state_in = S_WMODYW;
         S_WMODYW:  if (mod_done) state_in = S_PRD;
         S_PRD:     state_in = S_PDAT;
         S_PDAT:    state_in = S_RESP;
         S_OWN_RD:  state_in = S_OWN_DAT;
         S_OWN_DAT: state_in = S_TRIG_C;
         S_TRIG_C:  state_in = S_TRIG_W;
         S_TRIG_W:  if (sn_out_valid && sn_out_tag) state_in = copy ? S_WB : S_J_RD;
         S_J_RD: begin
            if (j_ff >= n_use) state_in = S_DISP;
            else if (j_ff != i_ff) state_in = S_J_DAT;
         end
         S_J_DAT:   state_in = S_J_MUL;
         S_J_MUL:   state_in = S_J_EVAL;
         S_J_EVAL:  state_in = S_J_RD;
         S_DISP:    state_in = S_MODX;
         S_MODX:    state_in = S_MODXW;
         S_MODXW:   if (mod_done) state_in = S_MODY;
         S_MODY:    state_in = S_MODYW;
         S_MODYW:   if (mod_done) state_in = S_WB;
         S_WB:      state_in = last_i ? S_RESP : S_OWN_RD;
         S_RESP:    if (rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs to memories and units
   always_comb begin
      pm_wr_en    = 1'b0;
      pm_wr_addr  = nb_base + PAW'(i_ff[AW-1:0]);
      pm_wr_data  = {newx_ff, newy_ff, newh_ff};
      pm_rd_en    = 1'b0;
      pm_rd_addr  = ob_base + PAW'(i_ff[AW-1:0]);
      nm_wr_en    = 1'b0;
      nm_wr_addr  = i_ff[AW-1:0];
      nm_wr_data  = (tot > CW'(255)) ? 8'd255 : 8'(tot);
      nm_rd_en    = 1'b0;
      nm_rd_addr  = AW'(idx_ff);
      mod_start   = 1'b0;
      mod_value   = 21'(dispx_ff) + $signed({3'b000, xi_ff});
      mod_modulus = wsz;
      sn_valid    = 1'b0;
      sn_tag      = 1'b0;
      sn_angle    = qang;
      unique case (state_ff)
         S_CLEAR: begin
            nm_wr_en   = 1'b1;
            nm_wr_data = '0;
         end
         S_WMODX: begin
            mod_start = 1'b1;
            mod_value = $signed({2'b00, px_ff});
         end
         S_WMODY: begin
            mod_start   = 1'b1;
            mod_value   = $signed({2'b00, py_ff});
            mod_modulus = hsz;
         end
         S_PRD: begin
            pm_rd_en   = 1'b1;
            pm_rd_addr = ob_base + PAW'(AW'(idx_ff));
            nm_rd_en   = 1'b1;
            pm_wr_en   = (kind_ff == KIND_WRITE) && idx_ok;
            pm_wr_addr = ob_base + PAW'(AW'(idx_ff));
            pm_wr_data = {newx_ff, newy_ff, head_ff};
         end
         S_OWN_RD:  pm_rd_en = 1'b1;
         S_OWN_DAT: sn_valid = 1'b1;
         S_TRIG_C: begin
            sn_valid = 1'b1;
            sn_tag   = 1'b1;
            sn_angle = ang_ff + 16'd16384;
         end
         S_J_RD: begin
            pm_rd_en   = 1'b1;
            pm_rd_addr = ob_base + PAW'(j_ff[AW-1:0]);
         end
         S_MODX:    mod_start = 1'b1;
         S_MODY: begin
            mod_start   = 1'b1;
            mod_value   = 21'(dispy_ff) + $signed({3'b000, yi_ff});
            mod_modulus = hsz;
         end
         S_WB: begin
            pm_wr_en = 1'b1;
            nm_wr_en = !copy;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bank_ff      <= 1'b0;
         steps_ff     <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            i_ff <= last_i ? '0 : i_ff + CW'(1);
         end
         if (req_acc) begin
            i_ff <= '0;
         end
         if (state_ff == S_WB) begin
            i_ff <= i_ff + CW'(1);
            if (last_i) begin
               bank_ff  <= !bank_ff;
               steps_ff <= steps_ff + 32'd1;
            end
         end
         if (state_ff == S_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff    <= req_chan.kind;
         idx_ff     <= req_chan.index;
         px_ff      <= req_chan.pos_x;
         py_ff      <= req_chan.pos_y;
         head_ff    <= req_chan.heading;
         res_idx_ff <= '0;
         res_x_ff   <= '0;
         res_y_ff   <= '0;
         res_h_ff   <= '0;
         res_n_ff   <= '0;
      end
      if ((state_ff == S_WMODXW || state_ff == S_MODXW) && mod_done) newx_ff <= mod_result;
      if ((state_ff == S_WMODYW || state_ff == S_MODYW) && mod_done) newy_ff <= mod_result;
      if (state_ff == S_PDAT) begin
         res_idx_ff <= idx_ff;
         if (idx_ok) begin
            res_n_ff <= nm_rd_data;
            if (kind_ff == KIND_WRITE) begin
               res_x_ff <= 19'(newx_ff);
               res_y_ff <= 19'(newy_ff);
               res_h_ff <= head_ff;
            end else begin
               res_x_ff <= 19'(ox);
               res_y_ff <= 19'(oy);
               res_h_ff <= oh;
            end
         end
      end
      if (state_ff == S_OWN_DAT) begin
         xi_ff  <= ox;
         yi_ff  <= oy;
         hi_ff  <= oh;
         ang_ff <= qang;
         l_ff   <= '0;
         r_ff   <= '0;
         j_ff   <= '0;
      end
      if (sn_out_valid) begin
         if (sn_out_tag) cos_ff <= sn_value;
         else sin_ff <= sn_value;
      end
      if (state_ff == S_TRIG_W) begin
         newx_ff <= xi_ff;
         newy_ff <= yi_ff;
         newh_ff <= hi_ff;
      end
      if (state_ff == S_J_RD && j_ff < n_use && j_ff == i_ff) j_ff <= j_ff + CW'(1);
      if (state_ff == S_J_DAT) begin
         dx_ff <= dxw;
         dy_ff <= dyw;
      end
      if (state_ff == S_J_MUL) begin
         pxx_ff <= dx_ff * dx_ff;
         pyy_ff <= dy_ff * dy_ff;
         psx_ff <= dx_ff * sin_ff;
         pcy_ff <= dy_ff * cos_ff;
      end
      if (state_ff == S_J_EVAL) begin
         j_ff <= j_ff + CW'(1);
         // strictly inside the radius; zero cross product counts right
         if (dist2 < $signed({9'd0, rad2_ff})) begin
            if (side > 38'sd0) l_ff <= l_ff + CW'(1);
            else r_ff <= r_ff + CW'(1);
         end
      end
      if (state_ff == S_DISP) begin
         dispx_ff <= 16'((vx + 30'sd8192) >>> 14);
         dispy_ff <= 16'((vy + 30'sd8192) >>> 14);
         newh_ff  <= hi_ff + turn;
      end
      if (state_ff == S_RESP && rsp_free) begin
         rsp_idx_ff <= res_idx_ff;
         rsp_x_ff   <= res_x_ff;
         rsp_y_ff   <= res_y_ff;
         rsp_h_ff   <= res_h_ff;
         rsp_n_ff   <= res_n_ff;
         rsp_s_ff   <= steps_ff;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.index_res   = rsp_idx_ff;
   assign rsp_chan.pos_x_res   = rsp_x_ff;
   assign rsp_chan.pos_y_res   = rsp_y_ff;
   assign rsp_chan.heading_res = rsp_h_ff;
   assign rsp_chan.neighbours  = rsp_n_ff;
   assign rsp_chan.step_count  = rsp_s_ff;
endmodule
`default_nettype wire

[rtl/core/pst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[rtl/core/pst_sine.sv]
`timescale 1ns / 1ps
`default_nettype none
module pst_sine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_tag,
   input  logic [pst_pkg::HEAD_W-1:0]    angle,
   output logic                          out_valid,
   output logic                          out_tag,
   output logic signed [pst_pkg::TRIG_W-1:0] value
);
   import pst_pkg::*;

   logic [1:0]  q;
   logic [13:0] r;
   logic [14:0] z;
   logic [29:0] zz;
   logic [31:0] m1, m2, m3;
   logic [15:0] t3;

   logic [3:0]  v_ff;
   logic [3:0]  tag_ff;
   logic [3:0]  neg_ff;
   logic [14:0] z1_ff, z2a_ff, z_2_ff, z2b_ff, z_3_ff;
   logic [13:0] t1_ff;
   logic [14:0] t2_ff;

   always_comb begin
      q  = angle[15:14];
      r  = angle[13:0];
      z  = q[0] ? 15'(15'd16384 - {1'b0, r}) : {1'b0, r};
      zz = z * z;
      m1 = 32'd1160 * 32'(z2a_ff);
      m2 = 32'(t1_ff) * 32'(z2b_ff);
      m3 = 32'(t2_ff) * 32'(z_3_ff);
      t3 = 16'(m3 >> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      tag_ff <= {tag_ff[2:0], in_tag};
      neg_ff <= {neg_ff[2:0], q[1]};
      z1_ff  <= z;
      z2a_ff <= 15'(zz >> 14);
      t1_ff  <= 14'(32'd10512 - (m1 >> 14));
      z2b_ff <= z2a_ff;
      z_2_ff <= z1_ff;
      t2_ff  <= 15'(32'd25736 - (m2 >> 14));
      z_3_ff <= z_2_ff;
      value  <= neg_ff[2] ? -$signed({1'b0, t3}) : $signed({1'b0, t3});
   end

   assign out_valid = v_ff[3];
   assign out_tag   = tag_ff[3];
endmodule
`default_nettype wire

[rtl/core/pst_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
module pst_mod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pst_pkg::MODV_W-1:0]   value,
   input  logic [pst_pkg::SIZE_W-1:0]          modulus,
   output logic                                done,
   output logic [pst_pkg::COORD_W-1:0]         result
);
   import pst_pkg::*;

   logic              busy_ff;
   logic [4:0]        cnt_ff;
   logic              neg_ff;
   logic [MODV_W-1:0] mag_ff;
   logic [19:0]       rem_ff;
   logic [SIZE_W-1:0] mod_ff;
   logic [19:0]       rem_shift, rem_step;

   always_comb begin
      rem_shift = {rem_ff[18:0], mag_ff[MODV_W-1]};
      rem_step  = (rem_shift >= {1'b0, mod_ff}) ? rem_shift - {1'b0, mod_ff} : rem_shift;
   end

   // restoring remainder, one bit per cycle, then sign fix-up
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(MODV_W);
            neg_ff  <= value[MODV_W-1];
            mag_ff  <= value[MODV_W-1] ? MODV_W'(-value) : MODV_W'(value);
            rem_ff  <= '0;
            mod_ff  <= modulus;
         end else if (busy_ff) begin
            if (cnt_ff != 5'd0) begin
               rem_ff <= rem_step;
               mag_ff <= {mag_ff[MODV_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 5'd1;
            end else begin
               result  <= (neg_ff && rem_ff != 20'd0) ? COORD_W'({1'b0, mod_ff} - rem_ff)
                                                        : COORD_W'(rem_ff);
               done    <= 1'b1;
               busy_ff <= 1'b0;
            end
         end
      end
   end
endmodule
`default_nettype wire
